/* hdl/dlcp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcp_pkg
// Shared constants and types of the downlink command parser.
// ----------------------------------------------------------------------------
package dlcp_pkg;

  localparam logic [7:0]  MAGIC_BYTE   = 8'hD1;
  localparam logic [7:0]  VERSION_BYTE = 8'h01;
  localparam logic [7:0]  CMD_INTERVAL = 8'h01;
  localparam logic [7:0]  CMD_SLAVE    = 8'h02;
  localparam logic [7:0]  CMD_STATUS   = 8'h03;
  localparam logic [7:0]  CMD_REBOOT   = 8'h04;
  localparam logic [31:0] INTERVAL_LO  = 32'd1000;
  localparam logic [31:0] INTERVAL_HI  = 32'd3600000;
  localparam logic [7:0]  SLAVE_LO     = 8'd1;
  localparam logic [7:0]  SLAVE_HI     = 8'd247;
  localparam logic [7:0]  REBOOT_KEY   = 8'hA5;

  localparam logic [7:0]  SLAVE_RESET    = 8'd1;
  localparam logic [21:0] INTERVAL_RESET = 22'd30000;

  localparam logic [2:0]  POS_MAX = 3'd7;

  localparam logic [4:0]  LEN_REJECT   = 5'd4;
  localparam logic [4:0]  LEN_SHORT_OK = 5'd5;
  localparam logic [4:0]  LEN_INTERVAL = 5'd8;
  localparam logic [4:0]  LEN_STATUS   = 5'd17;

  localparam int ECHO_W = 104;

  // ack byte slots ahead of the echoed values
  localparam logic [4:0]  IDX_MAGIC   = 5'd0;
  localparam logic [4:0]  IDX_VERSION = 5'd1;
  localparam logic [4:0]  IDX_CMD     = 5'd2;
  localparam logic [4:0]  IDX_STATUS  = 5'd3;

  typedef struct packed {
    logic [7:0]        cmd;
    logic              ok;
    logic [4:0]        len;
    logic [ECHO_W-1:0] echo;     // first echoed byte in the top bits
    logic              reboot;
    logic [7:0]        slave;
    logic [21:0]       interval;
  } job_t;

endpackage

/* hdl/dlcp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcp_front
// Collects frame bytes, checks the header, applies the command on the last
// byte and posts one ack job per answered frame.
// ----------------------------------------------------------------------------
module dlcp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        frame_byte_i,
  input  logic              frame_last_i,
  input  logic [31:0]       uplink_ok_count_i,
  input  logic [31:0]       read_ok_count_i,
  output logic              push_o,
  output dlcp_pkg::job_t    job_o
);

  logic [2:0]  pos_q, pos_d, pos_n;
  logic        hdr_bad_q, hdr_bad_d, hdr_bad_n;
  logic [7:0]  cmd_q, cmd_d, cmd_n;
  logic [31:0] payload_q, payload_d, payload_n;
  logic [7:0]  first_q, first_d, first_n;
  logic [7:0]  slave_q, slave_d;
  logic [21:0] interval_q, interval_d;
  logic        frame_ok;

  always_comb begin
    hdr_bad_n = hdr_bad_q;
    cmd_n     = cmd_q;
    payload_n = payload_q;
    first_n   = first_q;
    if (pos_q == 3'd0) begin
      hdr_bad_n = (frame_byte_i != dlcp_pkg::MAGIC_BYTE);
    end else if (pos_q == 3'd1) begin
      hdr_bad_n = hdr_bad_q | (frame_byte_i != dlcp_pkg::VERSION_BYTE);
    end else if (pos_q == 3'd2) begin
      cmd_n = frame_byte_i;
    end else if (pos_q != dlcp_pkg::POS_MAX) begin
      payload_n = {payload_q[23:0], frame_byte_i};
    end
    if (pos_q == 3'd3) begin
      first_n = frame_byte_i;
    end
    pos_n = (pos_q != dlcp_pkg::POS_MAX) ? pos_q + 3'd1 : dlcp_pkg::POS_MAX;
  end

  always_comb begin
    pos_d      = pos_q;
    hdr_bad_d  = hdr_bad_q;
    cmd_d      = cmd_q;
    payload_d  = payload_q;
    first_d    = first_q;
    slave_d    = slave_q;
    interval_d = interval_q;
    frame_ok   = (pos_n >= 3'd3) && !hdr_bad_n;

    job_o          = '0;
    job_o.cmd      = cmd_n;
    job_o.len      = dlcp_pkg::LEN_REJECT;

    if (accept_i && frame_last_i) begin
      unique case (cmd_n)
        dlcp_pkg::CMD_INTERVAL: begin
          if (pos_n == dlcp_pkg::POS_MAX && payload_n >= dlcp_pkg::INTERVAL_LO &&
              payload_n <= dlcp_pkg::INTERVAL_HI) begin
            interval_d = payload_n[21:0];
            job_o.ok   = 1'b1;
            job_o.len  = dlcp_pkg::LEN_INTERVAL;
            job_o.echo = {payload_n, 72'd0};
          end
        end
        dlcp_pkg::CMD_SLAVE: begin
          if (pos_n >= 3'd4 && first_n >= dlcp_pkg::SLAVE_LO &&
              first_n <= dlcp_pkg::SLAVE_HI) begin
            slave_d    = first_n;
            job_o.ok   = 1'b1;
            job_o.len  = dlcp_pkg::LEN_SHORT_OK;
            job_o.echo = {first_n, 96'd0};
          end
        end
        dlcp_pkg::CMD_STATUS: begin
          job_o.ok   = 1'b1;
          job_o.len  = dlcp_pkg::LEN_STATUS;
          job_o.echo = {slave_q, 10'd0, interval_q, uplink_ok_count_i, read_ok_count_i};
        end
        dlcp_pkg::CMD_REBOOT: begin
          if (pos_n >= 3'd4 && first_n == dlcp_pkg::REBOOT_KEY) begin
            job_o.ok     = 1'b1;
            job_o.reboot = 1'b1;
            job_o.len    = dlcp_pkg::LEN_SHORT_OK;
            job_o.echo   = {dlcp_pkg::REBOOT_KEY, 96'd0};
          end
        end
        default: begin
        end
      endcase
      if (!frame_ok) begin
        slave_d    = slave_q;
        interval_d = interval_q;
      end
      pos_d     = '0;
      hdr_bad_d = 1'b0;
      cmd_d     = '0;
      payload_d = '0;
      first_d   = '0;
    end else if (accept_i) begin
      pos_d     = pos_n;
      hdr_bad_d = hdr_bad_n;
      cmd_d     = cmd_n;
      payload_d = payload_n;
      first_d   = first_n;
    end
    job_o.slave    = slave_d;
    job_o.interval = interval_d;
    push_o         = accept_i && frame_last_i && frame_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_bad_q  <= 1'b0;
      cmd_q      <= '0;
      payload_q  <= '0;
      first_q    <= '0;
      slave_q    <= dlcp_pkg::SLAVE_RESET;
      interval_q <= dlcp_pkg::INTERVAL_RESET;
    end else begin
      pos_q      <= pos_d;
      hdr_bad_q  <= hdr_bad_d;
      cmd_q      <= cmd_d;
      payload_q  <= payload_d;
      first_q    <= first_d;
      slave_q    <= slave_d;
      interval_q <= interval_d;
    end
  end

endmodule

/* hdl/dlcp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcp_queue
// Two-entry job queue between the frame front end and the ack serializer.
// ----------------------------------------------------------------------------
module dlcp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dlcp_pkg::job_t    job_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output dlcp_pkg::job_t    job_o
);

  dlcp_pkg::job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job popped from empty queue");
`endif

endmodule

/* hdl/dlcp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcp_back
// Serializes one ack job into acknowledge bytes, one word per cycle while m_axis_tready is high.
// ----------------------------------------------------------------------------
module dlcp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  dlcp_pkg::job_t    job_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  output logic [0:0]        m_axis_tuser
);

  dlcp_pkg::job_t job_q, job_d;
  logic           busy_q, busy_d;
  logic [4:0]     idx_q, idx_d;
  logic [7:0]     ack_byte;
  logic           beat;

  always_comb begin
    case (idx_q)
      dlcp_pkg::IDX_MAGIC:   ack_byte = dlcp_pkg::MAGIC_BYTE;
      dlcp_pkg::IDX_VERSION: ack_byte = dlcp_pkg::VERSION_BYTE;
      dlcp_pkg::IDX_CMD:     ack_byte = job_q.cmd;
      dlcp_pkg::IDX_STATUS:  ack_byte = {7'd0, job_q.ok};
      default:               ack_byte = job_q.echo[dlcp_pkg::ECHO_W-1 -: 8];
    endcase
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = (idx_q == job_q.len - 5'd1);
  assign m_axis_tuser  = job_q.reboot;
  assign m_axis_tdata  = {2'b00, job_q.interval, job_q.slave, ack_byte};
  assign beat          = busy_q && m_axis_tready;

  always_comb begin
    job_d  = job_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    pop_o  = job_valid_i && (!busy_q || (beat && m_axis_tlast));
    if (pop_o) begin
      job_d  = job_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (beat) begin
      if (m_axis_tlast) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 5'd1;
        if (idx_q > dlcp_pkg::IDX_STATUS) begin
          job_d.echo = {job_q.echo[dlcp_pkg::ECHO_W-9:0], 8'd0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q < job_q.len)
    else $error("ack index past frame length");
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !m_axis_tready |=> busy_q && $stable(idx_q))
    else $error("ack advanced while stalled");
`endif

endmodule

/* hdl/downlink_command_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// downlink_command_parser_unit
// Downlink command frame parser with acknowledge generator.
// ----------------------------------------------------------------------------
// Input stream: one frame byte per word, tlast on the final byte; the two
// success counters ride along and are sampled with the final byte.
// Output stream: one acknowledge byte per word, tlast on the final byte,
// tuser flags an accepted reboot; slave address and interval after the
// frame travel with every byte.
// Input is taken at one word per cycle while the queue is not full. The last
// byte of an answered frame posts a job into a two-entry queue; the serializer
// pops it when idle or as its current ack ends, shows the first ack byte in
// the cycle after the pop, then sends 4, 5, 8 or 17 bytes at one per cycle
// while the receiver is ready, and the next job follows without a gap.
// Frames with a short or bad header give no ack. Input keeps being taken while
// the serializer sends earlier acks, so the slower side sets the sustained rate.
// A stalled receiver holds the current ack byte; input keeps flowing until
// two acks wait in the queue behind the one being sent, then s_axis_tready
// drops.
// Reset clears frame state, sets slave address 1 and interval 30000 ms and
// empties the queue.
// ----------------------------------------------------------------------------
module downlink_command_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // frame_byte, uplink_ok_count, read_ok_count
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // ack_byte, slave_address_now, interval_now, pad
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser   // reboot_request
);

  dlcp_pkg::job_t push_job, head_job;
  logic           push, pop, full, head_valid, accept;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  dlcp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .frame_byte_i      (s_axis_tdata[7:0]),
    .frame_last_i      (s_axis_tlast),
    .uplink_ok_count_i (s_axis_tdata[39:8]),
    .read_ok_count_i   (s_axis_tdata[71:40]),
    .push_o            (push),
    .job_o             (push_job)
  );

  dlcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  dlcp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (head_valid),
    .job_i         (head_job),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the downlink command parser unit.
// ----------------------------------------------------------------------------
// Frames go in one byte per word, built mostly from valid headers and
// commands with random, boundary and truncated payloads, plus noise and bad
// headers. A scoreboard predicts every acknowledge word from its own copy
// of the parser state and compares each output word field by field. Both
// stream sides idle at random, in phases, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [7:0]  ack_byte;
    logic        ack_last;
    logic        reboot;
    logic [7:0]  slave_addr;
    logic [21:0] poll_ms;
  } ack_word_t;

  class dlcp_scoreboard;
    logic [2:0]  pos;
    logic        hdr_bad;
    logic [7:0]  cmd_code;
    logic [31:0] payload;
    logic [7:0]  slave_addr;
    logic [21:0] poll_ms;
    ack_word_t   ack_q[$];
    int          errors;

    function new();
      pos        = '0;
      hdr_bad    = 1'b0;
      cmd_code   = '0;
      payload    = '0;
      slave_addr = dlcp_pkg::SLAVE_RESET;
      poll_ms    = dlcp_pkg::INTERVAL_RESET;
      errors     = 0;
    endfunction

    function void note_word(logic [7:0] b, logic last, logic [31:0] upc,
                            logic [31:0] rdc);
      int              n;
      int              len;
      logic [7:0]      first;
      logic            reboot;
      logic [0:16][7:0] ack;
      ack_word_t       w;
      if (pos == 3'd0) begin
        hdr_bad = (b != dlcp_pkg::MAGIC_BYTE);
      end else if (pos == 3'd1) begin
        hdr_bad = hdr_bad | (b != dlcp_pkg::VERSION_BYTE);
      end else if (pos == 3'd2) begin
        cmd_code = b;
      end else if (pos < dlcp_pkg::POS_MAX) begin
        payload = {payload[23:0], b};
      end
      n = (pos < dlcp_pkg::POS_MAX) ? int'(pos) + 1 : int'(dlcp_pkg::POS_MAX);
      pos = 3'(n);
      if (!last) return;
      if (n < 3 || hdr_bad) begin
        pos = '0; hdr_bad = 1'b0; cmd_code = '0; payload = '0;
        return;
      end
      first  = (n >= 4) ? 8'(payload >> (8 * (n - 4))) : 8'd0;
      reboot = 1'b0;
      ack    = '0;
      ack[dlcp_pkg::IDX_MAGIC]   = dlcp_pkg::MAGIC_BYTE;
      ack[dlcp_pkg::IDX_VERSION] = dlcp_pkg::VERSION_BYTE;
      ack[dlcp_pkg::IDX_CMD]     = cmd_code;
      len = int'(dlcp_pkg::LEN_REJECT);
      case (cmd_code)
        dlcp_pkg::CMD_INTERVAL: begin
          if (n >= 7 && payload >= dlcp_pkg::INTERVAL_LO &&
              payload <= dlcp_pkg::INTERVAL_HI) begin
            poll_ms                   = payload[21:0];
            ack[dlcp_pkg::IDX_STATUS] = 8'd1;
            ack[4:7]                  = payload;
            len                       = int'(dlcp_pkg::LEN_INTERVAL);
          end
        end
        dlcp_pkg::CMD_SLAVE: begin
          if (n >= 4 && first >= dlcp_pkg::SLAVE_LO && first <= dlcp_pkg::SLAVE_HI) begin
            slave_addr                = first;
            ack[dlcp_pkg::IDX_STATUS] = 8'd1;
            ack[4]                    = first;
            len                       = int'(dlcp_pkg::LEN_SHORT_OK);
          end
        end
        dlcp_pkg::CMD_STATUS: begin
          ack[dlcp_pkg::IDX_STATUS] = 8'd1;
          ack[4]                    = slave_addr;
          ack[5:8]                  = {10'd0, poll_ms};
          ack[9:12]                 = upc;
          ack[13:16]                = rdc;
          len                       = int'(dlcp_pkg::LEN_STATUS);
        end
        dlcp_pkg::CMD_REBOOT: begin
          if (n >= 4 && first == dlcp_pkg::REBOOT_KEY) begin
            reboot                    = 1'b1;
            ack[dlcp_pkg::IDX_STATUS] = 8'd1;
            ack[4]                    = dlcp_pkg::REBOOT_KEY;
            len                       = int'(dlcp_pkg::LEN_SHORT_OK);
          end
        end
        default: ;
      endcase
      pos = '0; hdr_bad = 1'b0; cmd_code = '0; payload = '0;
      for (int k = 0; k < len; k++) begin
        w.ack_byte   = ack[k];
        w.ack_last   = (k == len - 1);
        w.reboot     = reboot;
        w.slave_addr = slave_addr;
        w.poll_ms    = poll_ms;
        ack_q.push_back(w);
      end
    endfunction

    function void check_word(ack_word_t got);
      ack_word_t exp_w;
      if (ack_q.size() == 0) begin
        $error("unexpected ack word %0h", got);
        errors++;
        return;
      end
      exp_w = ack_q.pop_front();
      if (got.ack_byte != exp_w.ack_byte) begin
        $error("ack_byte: expected %0h got %0h", exp_w.ack_byte, got.ack_byte);
        errors++;
      end
      if (got.ack_last != exp_w.ack_last) begin
        $error("ack_last: expected %0d got %0d", exp_w.ack_last, got.ack_last);
        errors++;
      end
      if (got.reboot != exp_w.reboot) begin
        $error("reboot_request: expected %0d got %0d", exp_w.reboot, got.reboot);
        errors++;
      end
      if (got.slave_addr != exp_w.slave_addr) begin
        $error("slave_address_now: expected %0d got %0d", exp_w.slave_addr,
               got.slave_addr);
        errors++;
      end
      if (got.poll_ms != exp_w.poll_ms) begin
        $error("interval_now: expected %0d got %0d", exp_w.poll_ms,
               got.poll_ms);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;

  dlcp_scoreboard sb;
  logic [7:0]     frame_q[$];
  int             words_sent = 0;
  int             tx_idle_pct = 0;
  int             rx_stall_pct = 0;
  logic           rx_hold = 1'b0;

  downlink_command_parser_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tlast (m_tlast),
    .m_axis_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rx_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && m_tvalid && m_tready) begin
      sb.check_word('{m_tdata[7:0], m_tlast, m_tuser[0], m_tdata[15:8],
                      m_tdata[37:16]});
    end
  end

  task automatic send_word(logic [7:0] b, logic last, logic [31:0] upc,
                           logic [31:0] rdc);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rdc, upc, b};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(b, last, upc, rdc);
    words_sent++;
  endtask

  task automatic send_frame(logic [31:0] upc, logic [31:0] rdc);
    foreach (frame_q[k]) begin
      if (k == frame_q.size() - 1) begin
        send_word(frame_q[k], 1'b1, upc, rdc);
      end else begin
        send_word(frame_q[k], 1'b0, $urandom, $urandom);
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.ack_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic make_frame();
    int          kind;
    int          plen;
    int          r;
    logic [7:0]  cmd;
    logic [31:0] val;
    frame_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      plen = $urandom_range(1, 10);
      repeat (plen) frame_q.push_back(8'($urandom));
      if ($urandom_range(0, 1)) frame_q[0] = dlcp_pkg::MAGIC_BYTE;
      return;
    end
    frame_q.push_back((kind < 15) ? 8'($urandom) : dlcp_pkg::MAGIC_BYTE);
    frame_q.push_back((kind >= 15 && kind < 20) ? 8'($urandom) : dlcp_pkg::VERSION_BYTE);
    r   = $urandom_range(0, 9);
    cmd = (r < 2) ? 8'($urandom) : 8'($urandom_range(1, 4));
    frame_q.push_back(cmd);
    val  = $urandom;
    plen = 0;
    case (cmd)
      dlcp_pkg::CMD_INTERVAL: begin
        plen = 4;
        case ($urandom_range(0, 6))
          0: val = dlcp_pkg::INTERVAL_LO;
          1: val = dlcp_pkg::INTERVAL_HI;
          2: val = dlcp_pkg::INTERVAL_LO - 1;
          3: val = dlcp_pkg::INTERVAL_HI + 1;
          4: val = $urandom;
          default: val = $urandom_range(dlcp_pkg::INTERVAL_HI, dlcp_pkg::INTERVAL_LO);
        endcase
      end
      dlcp_pkg::CMD_SLAVE: begin
        plen = 1;
        case ($urandom_range(0, 5))
          0: val[31:24] = dlcp_pkg::SLAVE_LO;
          1: val[31:24] = dlcp_pkg::SLAVE_HI;
          2: val[31:24] = 8'd0;
          3: val[31:24] = dlcp_pkg::SLAVE_HI + 8'd1;
          default: ;
        endcase
      end
      dlcp_pkg::CMD_REBOOT: begin
        plen = 1;
        if ($urandom_range(0, 99) < 60) val[31:24] = dlcp_pkg::REBOOT_KEY;
      end
      default: ;
    endcase
    // truncated or overlong payload
    if ($urandom_range(0, 99) < 15) plen = $urandom_range(0, 6);
    for (int k = 0; k < plen; k++) begin
      frame_q.push_back((k < 4) ? val[31 - 8*k -: 8] : 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_n    <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    frame_q = '{dlcp_pkg::MAGIC_BYTE, dlcp_pkg::VERSION_BYTE, dlcp_pkg::CMD_STATUS};
    send_frame(32'hFFFF_FFFF, 32'h0);
    frame_q = '{dlcp_pkg::MAGIC_BYTE, dlcp_pkg::VERSION_BYTE, dlcp_pkg::CMD_INTERVAL,
                8'h00, 8'h00, 8'h03, 8'hE8};
    send_frame(32'h0, 32'hFFFF_FFFF);
    frame_q = '{dlcp_pkg::MAGIC_BYTE, dlcp_pkg::VERSION_BYTE, dlcp_pkg::CMD_SLAVE,
                dlcp_pkg::SLAVE_HI};
    send_frame($urandom, $urandom);
    frame_q = '{dlcp_pkg::MAGIC_BYTE, dlcp_pkg::VERSION_BYTE, dlcp_pkg::CMD_REBOOT,
                dlcp_pkg::REBOOT_KEY};
    send_frame($urandom, $urandom);
    frame_q = '{dlcp_pkg::MAGIC_BYTE, dlcp_pkg::VERSION_BYTE, 8'hFF};
    send_frame($urandom, $urandom);
    frame_q = '{dlcp_pkg::MAGIC_BYTE, dlcp_pkg::VERSION_BYTE};
    send_frame($urandom, $urandom);
    frame_q = '{8'h00, dlcp_pkg::VERSION_BYTE, dlcp_pkg::CMD_STATUS};
    send_frame($urandom, $urandom);
    frame_q = '{dlcp_pkg::MAGIC_BYTE, dlcp_pkg::VERSION_BYTE, dlcp_pkg::CMD_STATUS};
    send_frame($urandom, $urandom);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
      endcase
      if (ph == 2) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (400) @(posedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      while (words_sent < 30 + (ph + 1) * 113) begin
        make_frame();
        send_frame($urandom, $urandom);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
